[hdl/nlb_pkg.sv]
package nlb_pkg;

    // Accumulator width, 64 to 128; the value wraps modulo 2^ACC_WIDTH.
    localparam int ACC_WIDTH = 128;

    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_ZERO       = 8'h30;
    localparam logic [7:0] CH_ONE        = 8'h31;
    localparam logic [7:0] CH_NINE       = 8'h39;
    localparam logic [7:0] CH_LOWER_X    = 8'h78;
    localparam logic [7:0] CH_UPPER_X    = 8'h58;
    localparam logic [7:0] CH_LOWER_B    = 8'h62;
    localparam logic [7:0] CH_UPPER_B    = 8'h42;
    localparam logic [7:0] CH_LOWER_A    = 8'h61;
    localparam logic [7:0] CH_LOWER_F    = 8'h66;
    localparam logic [7:0] CH_UPPER_A    = 8'h41;
    localparam logic [7:0] CH_UPPER_F    = 8'h46;
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_LOWER_E    = 8'h65;
    localparam logic [7:0] CH_UPPER_E    = 8'h45;

    typedef enum logic [1:0] {
        RADIX_DEC = 2'd0,
        RADIX_HEX = 2'd1,
        RADIX_BIN = 2'd2
    } t_radix;

    typedef struct packed {
        logic [7:0] character;
        logic       char_present;
        logic       last_char;
    } t_in_beat;

    typedef struct packed {
        logic [63:0] value_low;
        logic [63:0] value_high;
        logic        is_float;
    } t_out_beat;

endpackage

[hdl/nlb_in_reg.sv]
module nlb_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  nlb_pkg::t_in_beat i_data,
    output logic              o_stall,
    output logic              o_valid,
    output nlb_pkg::t_in_beat o_data,
    input  logic              i_take
);

    logic              r_valid;
    nlb_pkg::t_in_beat r_data;
    logic              accept;

    assign o_stall = r_valid && !i_take;
    assign accept  = i_valid && !o_stall;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= accept || (r_valid && !i_take);
        end
        if (accept) begin
            r_data <= i_data;
        end
    end

endmodule

[hdl/nlb_accum.sv]
module nlb_accum (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_beat_valid,
    input  nlb_pkg::t_in_beat  i_beat,
    input  logic               i_out_free,
    output logic               o_take,
    output logic               o_result_load,
    output nlb_pkg::t_out_beat o_result
);

    localparam int W = nlb_pkg::ACC_WIDTH;

    logic [W-1:0]    r_acc, n_acc;
    logic [1:0]      r_pos, n_pos;
    nlb_pkg::t_radix r_mode, n_mode;
    logic            r_first_zero, n_first_zero;
    logic            r_stopped, n_stopped;
    logic            r_float, n_float;

    logic [7:0]       c;
    logic signed [8:0] dec_d;
    logic [W-1:0]     mac10, mac16, mac2;
    logic [3:0]       hex_d;
    logic             hex_ok;
    logic             is_mark;
    logic [127:0]     value_ext;

    assign c = i_beat.character;

    // Last beat waits for room in the result register; all others flow through.
    assign o_take        = i_beat_valid && (!i_beat.last_char || i_out_free);
    assign o_result_load = o_take && i_beat.last_char;

    always_comb begin
        dec_d = $signed({1'b0, c}) - 9'sd48;
        mac10 = (r_acc << 3) + (r_acc << 1) + {{(W-9){dec_d[8]}}, dec_d};
        mac2  = (r_acc << 1) + W'(c == nlb_pkg::CH_ONE);
        hex_ok = 1'b1;
        hex_d  = 4'd0;
        if (c >= nlb_pkg::CH_ZERO && c <= nlb_pkg::CH_NINE) begin
            hex_d = c[3:0];
        end else if ((c >= nlb_pkg::CH_LOWER_A && c <= nlb_pkg::CH_LOWER_F)
                  || (c >= nlb_pkg::CH_UPPER_A && c <= nlb_pkg::CH_UPPER_F)) begin
            hex_d = c[3:0] + 4'd9;
        end else begin
            hex_ok = 1'b0;
        end
        mac16   = (r_acc << 4) + W'(hex_d);
        is_mark = (c == nlb_pkg::CH_DOT) || (c == nlb_pkg::CH_LOWER_E)
                  || (c == nlb_pkg::CH_UPPER_E);
    end

    always_comb begin
        n_acc        = r_acc;
        n_pos        = r_pos;
        n_mode       = r_mode;
        n_first_zero = r_first_zero;
        n_stopped    = r_stopped;
        n_float      = r_float;
        if (i_beat.char_present) begin
            if (r_pos == 2'd0) begin
                n_first_zero = (c == nlb_pkg::CH_ZERO);
                n_pos        = 2'd1;
                if (is_mark) n_float = 1'b1;
                if (c != nlb_pkg::CH_UNDERSCORE) n_acc = mac10;
            end else if (r_pos == 2'd1) begin
                n_pos = 2'd2;
                if (r_first_zero && (c == nlb_pkg::CH_LOWER_X
                                     || c == nlb_pkg::CH_UPPER_X)) begin
                    n_mode = nlb_pkg::RADIX_HEX;
                    n_acc  = '0;
                end else if (r_first_zero && (c == nlb_pkg::CH_LOWER_B
                                              || c == nlb_pkg::CH_UPPER_B)) begin
                    n_mode = nlb_pkg::RADIX_BIN;
                    n_acc  = '0;
                end else begin
                    if (is_mark) n_float = 1'b1;
                    if (c != nlb_pkg::CH_UNDERSCORE) n_acc = mac10;
                end
            end else if (r_mode == nlb_pkg::RADIX_DEC) begin
                if (is_mark) n_float = 1'b1;
                if (c != nlb_pkg::CH_UNDERSCORE) n_acc = mac10;
            end else if (!r_stopped && c != nlb_pkg::CH_UNDERSCORE) begin
                if (r_mode == nlb_pkg::RADIX_HEX) begin
                    if (hex_ok) n_acc = mac16;
                    else        n_stopped = 1'b1;
                end else begin
                    if (c == nlb_pkg::CH_ZERO || c == nlb_pkg::CH_ONE) n_acc = mac2;
                    else                                                n_stopped = 1'b1;
                end
            end
        end
    end

    assign value_ext           = 128'(n_acc);
    assign o_result.value_low  = value_ext[63:0];
    assign o_result.value_high = value_ext[127:64];
    assign o_result.is_float   = (n_mode == nlb_pkg::RADIX_DEC) && n_float;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc        <= '0;
            r_pos        <= 2'd0;
            r_mode       <= nlb_pkg::RADIX_DEC;
            r_first_zero <= 1'b0;
            r_stopped    <= 1'b0;
            r_float      <= 1'b0;
        end else if (o_take) begin
            if (i_beat.last_char) begin
                r_acc        <= '0;
                r_pos        <= 2'd0;
                r_mode       <= nlb_pkg::RADIX_DEC;
                r_first_zero <= 1'b0;
                r_stopped    <= 1'b0;
                r_float      <= 1'b0;
            end else begin
                r_acc        <= n_acc;
                r_pos        <= n_pos;
                r_mode       <= n_mode;
                r_first_zero <= n_first_zero;
                r_stopped    <= n_stopped;
                r_float      <= n_float;
            end
        end
    end

    a_reset_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_load |=> (r_pos == 2'd0) && (r_acc == '0)
                          && (r_mode == nlb_pkg::RADIX_DEC) && !r_float)
        else $error("literal state not cleared after last beat");

    a_prefix_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode != nlb_pkg::RADIX_DEC) |-> (r_pos == 2'd2))
        else $error("radix prefix seen before second character");

    a_stop_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped |-> (r_mode != nlb_pkg::RADIX_DEC))
        else $error("digit freeze in decimal mode");

    a_non_last_flows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_beat_valid && !i_beat.last_char) |-> o_take)
        else $error("non-final beat held back");

endmodule

[hdl/nlb_out_reg.sv]
module nlb_out_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  nlb_pkg::t_out_beat i_data,
    output logic               o_free,
    output logic               o_valid,
    output nlb_pkg::t_out_beat o_data,
    input  logic               i_stall
);

    logic               r_valid;
    nlb_pkg::t_out_beat r_data;

    assign o_free  = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_load || (r_valid && i_stall);
        end
        if (i_load) begin
            r_data <= i_data;
        end
    end

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("result loaded over a stalled beat");

    a_held_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_stall) |=> r_valid && $stable(r_data))
        else $error("stalled result lost or changed");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_stall && !i_load) |=> !r_valid)
        else $error("delivered result repeated");

endmodule

[hdl/number_literal_to_binary.sv]
// Numeric literal to binary converter.
// Input channel (i_in_valid / o_in_stall / i_in_data): one character of the
// literal per beat, last_char set on the final one. A beat with char_present
// low is skipped; with last_char also set it closes the literal.
// Output channel (o_out_valid / i_out_stall / o_out_data): one result beat per
// literal, the 128-bit value split into value_low / value_high, and is_float.
// 0x/0X selects hex, 0b/0B binary; otherwise decimal.
// Throughput: one character per cycle, except while a final beat waits for
// room in the output register. Each beat is captured in an input register
// and then folded into the accumulator by a single shift-add (x10, x16 or
// x2 plus digit). The result of a final beat is loaded into the output
// register as soon as that register is free, and the receiver takes it there.
// When the receiver stalls, the result holds in the output register; the
// input register still takes one more beat, and characters that are not
// final keep flowing. A second final beat waits until the result is taken.
// Reset (synchronous, active low) drops both registers' valid flags and
// returns the converter to a fresh decimal literal with a zero accumulator.
module number_literal_to_binary (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  nlb_pkg::t_in_beat  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output nlb_pkg::t_out_beat o_out_data
);

    logic               beat_valid;
    nlb_pkg::t_in_beat  beat;
    logic               take;
    logic               out_free;
    logic               result_load;
    nlb_pkg::t_out_beat result;

    nlb_in_reg u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_data  (i_in_data),
        .o_stall (o_in_stall),
        .o_valid (beat_valid),
        .o_data  (beat),
        .i_take  (take)
    );

    nlb_accum u_accum (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_beat_valid  (beat_valid),
        .i_beat        (beat),
        .i_out_free    (out_free),
        .o_take        (take),
        .o_result_load (result_load),
        .o_result      (result)
    );

    nlb_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (result_load),
        .i_data  (result),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .o_data  (o_out_data),
        .i_stall (i_out_stall)
    );

endmodule
